// File: rtl/iri_pkg.sv
// Shared constants, types and codes for the image resize interpolator.
`timescale 1ns / 1ps
package iri_pkg;

  localparam int MAX_WIDTH    = 256;
  localparam int MAX_HEIGHT   = 256;
  localparam int MAX_CHANNELS = 4;
  localparam int SAMPLE_BITS  = 16;
  localparam int DST_LIMIT    = 4096;

  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int YW  = $clog2(MAX_HEIGHT);
  localparam int CW  = $clog2(MAX_CHANNELS);
  localparam int CRW = (XW > YW) ? XW : YW;

  localparam int POSW = 12;
  localparam int CHW  = 2;
  localparam int SRCW = 9;
  localparam int CNTW = 3;
  localparam int DSTW = 13;
  localparam int CFGW = DSTW;
  localparam int IDXW = 3;

  localparam int FW   = 16;
  localparam int NUMW = DSTW + SRCW;
  localparam int NW   = NUMW + FW;
  localparam int QW   = CRW + FW + 1;
  localparam int RW   = DSTW + 2;
  localparam int DDW  = DSTW + 1;
  localparam int WW   = FW + 1;
  localparam int HW   = SAMPLE_BITS + WW;
  localparam int ACW  = HW + WW;

  localparam int BANKS      = 4;
  localparam int BAW        = (XW - 1) + (YW - 1) + CW;
  localparam int BANK_DEPTH = 1 << BAW;

  localparam int QDEPTH = 4;
  localparam int QPW    = $clog2(QDEPTH);
  localparam int QCW    = QPW + 1;

  localparam logic FUNC_WRITE    = 1'b0;
  localparam logic FUNC_QUERY    = 1'b1;
  localparam logic MODE_NEAREST  = 1'b0;
  localparam logic MODE_BILINEAR = 1'b1;

  localparam logic [IDXW-1:0] REG_SRC_WIDTH     = 3'd0;
  localparam logic [IDXW-1:0] REG_SRC_HEIGHT    = 3'd1;
  localparam logic [IDXW-1:0] REG_CHANNEL_COUNT = 3'd2;
  localparam logic [IDXW-1:0] REG_DST_WIDTH     = 3'd3;
  localparam logic [IDXW-1:0] REG_DST_HEIGHT    = 3'd4;
  localparam logic [IDXW-1:0] REG_INTERP_MODE   = 3'd5;

  typedef struct packed {
    logic [SRCW-1:0] sw;
    logic [SRCW-1:0] sh;
    logic [CNTW-1:0] nc;
    logic [DSTW-1:0] dw;
    logic [DSTW-1:0] dh;
    logic            mode;
  } cfg_t;

  typedef struct packed {
    logic                   func;
    logic                   wok;
    logic                   bad;
    logic [CHW-1:0]         chan;
    logic [XW-1:0]          wcol;
    logic [YW-1:0]          wrow;
    logic [SAMPLE_BITS-1:0] sample;
    logic [NUMW-1:0]        numx;
    logic [NUMW-1:0]        numy;
  } entry_t;

  typedef struct packed {
    logic [RW-1:0] r;
    logic [QW-1:0] n;
    logic [QW-1:0] q;
  } div_t;

endpackage

// File: rtl/iri_front.sv
// Front end: classifies items, range checks and forms mapping numerators.
`timescale 1ns / 1ps
module iri_front (
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           func,
  input  logic [iri_pkg::POSW-1:0]       col,
  input  logic [iri_pkg::POSW-1:0]       row,
  input  logic [iri_pkg::CHW-1:0]        chan,
  input  logic [iri_pkg::SAMPLE_BITS-1:0] sample_in,
  input  iri_pkg::cfg_t                  cfg,
  input  logic                           q_ready,
  output logic                           push,
  output iri_pkg::entry_t                entry
);
  import iri_pkg::*;

  logic [DSTW-1:0] ox, oy;

  assign in_ready = q_ready;
  assign push     = in_valid & q_ready;
  assign ox       = {col, 1'b1};
  assign oy       = {row, 1'b1};

  always_comb begin
    entry.func   = func;
    entry.wok    = (32'(col) < MAX_WIDTH) && (32'(row) < MAX_HEIGHT) &&
                   (32'(chan) < MAX_CHANNELS);
    entry.bad    = ({1'b0, col} >= cfg.dw) || ({1'b0, row} >= cfg.dh) ||
                   ({1'b0, chan} >= cfg.nc);
    entry.chan   = chan;
    entry.wcol   = col[XW-1:0];
    entry.wrow   = row[YW-1:0];
    entry.sample = sample_in;
    entry.numx   = NUMW'(ox) * NUMW'(cfg.sw);
    entry.numy   = NUMW'(oy) * NUMW'(cfg.sh);
  end

endmodule

// File: rtl/iri_queue.sv
// Short queue between the front end and the back end.
`timescale 1ns / 1ps
module iri_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  iri_pkg::entry_t push_data,
  output logic            q_ready,
  input  logic            pop,
  output logic            q_valid,
  output iri_pkg::entry_t q_data
);
  import iri_pkg::*;

  entry_t           slots [QDEPTH];
  logic [QPW-1:0]   wptr, rptr;
  logic [QCW-1:0]   count;

  assign q_ready = (count != QCW'(QDEPTH));
  assign q_valid = (count != '0);
  assign q_data  = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      count <= count + QCW'(push) - QCW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= push_data;
  end

endmodule

// File: rtl/iri_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module iri_div (
  input  logic                    clk,
  input  logic                    adv,
  input  logic [iri_pkg::NW-1:0]  num,
  input  logic [iri_pkg::DDW-1:0] den,
  output logic [iri_pkg::QW-1:0]  quo
);
  import iri_pkg::*;

  div_t st [QW+1];

  function automatic div_t div_step(div_t s, logic [DDW-1:0] d);
    logic [RW-1:0] t;
    div_t          o;
    t = {s.r[RW-2:0], s.n[QW-1]};
    o = s;
    if (t >= RW'(d)) begin
      o.r = t - RW'(d);
      o.q = {s.q[QW-2:0], 1'b1};
    end else begin
      o.r = t;
      o.q = {s.q[QW-2:0], 1'b0};
    end
    o.n = {s.n[QW-2:0], 1'b0};
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      st[0].r <= RW'(num[NW-1:QW]);
      st[0].n <= num[QW-1:0];
      st[0].q <= '0;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (adv) st[k+1] <= div_step(st[k], den);
    end
  end

  assign quo = st[QW].q;

endmodule

// File: rtl/iri_back.sv
// Back end: coordinate mapping, banked frame store and weighting pipeline.
`timescale 1ns / 1ps
module iri_back (
  input  logic                            clk,
  input  logic                            rst,
  input  iri_pkg::cfg_t                   cfg,
  input  logic                            q_valid,
  input  iri_pkg::entry_t                 q_data,
  output logic                            pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [iri_pkg::SAMPLE_BITS-1:0] sample_out,
  output logic                            status
);
  import iri_pkg::*;

  typedef struct packed {
    logic [CRW-1:0] lo;
    logic [CRW-1:0] hi;
    logic [FW-1:0]  f;
  } axis_t;

  localparam int IPW = QW - FW + 1;
  localparam int RNW = ACW - 2 * FW;
  localparam int SB  = SAMPLE_BITS;

  function automatic axis_t axis_map(logic [QW-1:0] t, logic [SRCW-1:0] s, logic m);
    logic [SRCW-1:0] lim;
    logic [IPW-1:0]  lx, ip, im;
    logic [QW:0]     u;
    axis_t           o;
    lim = s - 1'b1;
    lx  = IPW'(lim);
    u   = {1'b0, t} + ((QW+1)'(1) << (FW - 1));
    if (m == MODE_NEAREST) begin
      ip   = {1'b0, t[QW-1:FW]};
      ip   = (ip > lx) ? lx : ip;
      o.lo = ip[CRW-1:0];
      o.hi = ip[CRW-1:0];
      o.f  = '0;
    end else begin
      ip   = u[QW:FW];
      im   = ip - 1'b1;
      o.hi = (ip > lx) ? lx[CRW-1:0] : ip[CRW-1:0];
      o.lo = (ip == '0) ? '0 : ((im > lx) ? lx[CRW-1:0] : im[CRW-1:0]);
      o.f  = u[FW-1:0];
    end
    return o;
  endfunction

  function automatic logic [SB-1:0] pick4(logic [BANKS*SB-1:0] v, logic py, logic px);
    logic [SB-1:0] r;
    unique case ({py, px})
      2'b00:   r = v[SB-1:0];
      2'b01:   r = v[2*SB-1:SB];
      2'b10:   r = v[3*SB-1:2*SB];
      default: r = v[4*SB-1:3*SB];
    endcase
    return r;
  endfunction

  logic            adv;
  logic [NW-1:0]   nx, ny;
  logic [DDW-1:0]  den_x, den_y;
  logic [QW-1:0]   qx, qy;
  logic            vl [QW+1];
  entry_t          pl [QW+1];

  axis_t           ax, ay;
  logic [BAW-1:0]  addr_next [BANKS];
  logic [BANKS-1:0] we_next;

  logic            c_v;
  entry_t          c_pay;
  logic [BAW-1:0]  c_addr [BANKS];
  logic [BANKS-1:0] c_we;
  logic [3:0]      c_sel;
  logic [FW-1:0]   c_fx, c_fy;

  logic            m_v;
  logic            m_func, m_bad;
  logic [3:0]      m_sel;
  logic [FW-1:0]   m_fx, m_fy;
  logic [BANKS*SB-1:0] rdata;

  logic            h_v, h_func, h_bad;
  logic [HW-1:0]   h_top, h_bot;
  logic [FW-1:0]   h_fy;

  logic            v_v, v_func, v_bad;
  logic [ACW-1:0]  acc;

  logic [SB-1:0]   v1, v2, v3, v4;
  logic [WW-1:0]   gx, fxw, gy, fyw;
  logic [RNW-1:0]  rnd;

  assign adv   = !out_valid || out_ready;
  assign pop   = adv && q_valid;
  assign nx    = {q_data.numx, FW'(0)} + NW'(cfg.dw);
  assign ny    = {q_data.numy, FW'(0)} + NW'(cfg.dh);
  assign den_x = {cfg.dw, 1'b0};
  assign den_y = {cfg.dh, 1'b0};

  iri_div u_div_x (.clk(clk), .adv(adv), .num(nx), .den(den_x), .quo(qx));
  iri_div u_div_y (.clk(clk), .adv(adv), .num(ny), .den(den_y), .quo(qy));

  always_ff @(posedge clk) begin
    if (rst) begin
      vl[0] <= 1'b0;
    end else if (adv) begin
      vl[0] <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) pl[0] <= q_data;
  end

  for (genvar k = 0; k < QW; k++) begin : g_line
    always_ff @(posedge clk) begin
      if (rst) begin
        vl[k+1] <= 1'b0;
      end else if (adv) begin
        vl[k+1] <= vl[k];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) pl[k+1] <= pl[k];
    end
  end

  always_comb begin
    logic [CRW-1:0] cx, cy;
    logic [BAW-1:0] ra, wa;
    ax = axis_map(qx, cfg.sw, cfg.mode);
    ay = axis_map(qy, cfg.sh, cfg.mode);
    wa = {pl[QW].wrow[YW-1:1], pl[QW].wcol[XW-1:1], pl[QW].chan[CW-1:0]};
    for (int b = 0; b < BANKS; b++) begin
      cx = (ax.lo[0] == b[0]) ? ax.lo : ax.hi;
      cy = (ay.lo[0] == b[1]) ? ay.lo : ay.hi;
      ra = {cy[YW-1:1], cx[XW-1:1], pl[QW].chan[CW-1:0]};
      addr_next[b] = (pl[QW].func == FUNC_WRITE) ? wa : ra;
      we_next[b]   = vl[QW] && (pl[QW].func == FUNC_WRITE) && pl[QW].wok &&
                     ({pl[QW].wrow[0], pl[QW].wcol[0]} == 2'(b));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
      m_v <= 1'b0;
      h_v <= 1'b0;
      v_v <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      c_v <= vl[QW];
      m_v <= c_v;
      h_v <= m_v;
      v_v <= h_v;
      out_valid <= v_v && (v_func == FUNC_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_pay  <= pl[QW];
      c_addr <= addr_next;
      c_we   <= we_next;
      c_sel  <= {ay.lo[0], ay.hi[0], ax.lo[0], ax.hi[0]};
      c_fx   <= ax.f;
      c_fy   <= ay.f;
    end
  end

  for (genvar gb = 0; gb < BANKS; gb++) begin : g_bank
    logic [SB-1:0] ram [BANK_DEPTH];
    always_ff @(posedge clk) begin
      if (adv) begin
        if (c_v && c_we[gb]) ram[c_addr[gb]] <= c_pay.sample;
        rdata[gb*SB +: SB] <= ram[c_addr[gb]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_func <= c_pay.func;
      m_bad  <= c_pay.bad;
      m_sel  <= c_sel;
      m_fx   <= c_fx;
      m_fy   <= c_fy;
    end
  end

  assign v1  = pick4(rdata, m_sel[3], m_sel[1]);
  assign v2  = pick4(rdata, m_sel[3], m_sel[0]);
  assign v3  = pick4(rdata, m_sel[2], m_sel[1]);
  assign v4  = pick4(rdata, m_sel[2], m_sel[0]);
  assign fxw = WW'(m_fx);
  assign gx  = (WW'(1) << FW) - fxw;
  assign fyw = WW'(h_fy);
  assign gy  = (WW'(1) << FW) - fyw;

  always_ff @(posedge clk) begin
    if (adv) begin
      h_func <= m_func;
      h_bad  <= m_bad;
      h_fy   <= m_fy;
      h_top  <= HW'(v1) * HW'(gx) + HW'(v2) * HW'(fxw);
      h_bot  <= HW'(v3) * HW'(gx) + HW'(v4) * HW'(fxw);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      v_func <= h_func;
      v_bad  <= h_bad;
      acc    <= ACW'(h_top) * ACW'(gy) + ACW'(h_bot) * ACW'(fyw);
    end
  end

  assign rnd = acc[ACW-1:2*FW] + RNW'(acc[2*FW-1]);

  always_ff @(posedge clk) begin
    if (adv) begin
      status <= v_bad;
      if (v_bad) begin
        sample_out <= '0;
      end else if (rnd > RNW'({SB{1'b1}})) begin
        sample_out <= '1;
      end else begin
        sample_out <= rnd[SB-1:0];
      end
    end
  end

endmodule

// File: rtl/image_resize_interpolator_core.sv
// Top level of the image resize interpolator: registers, front end, queue, back end.
//
//  channel  signals                                  direction
//  input    in_valid/in_ready, func col row chan     in
//           sample_in
//  output   out_valid/out_ready, sample_out status   out
//  config   cfg_we cfg_index cfg_data                in, write only
//
//  One item per cycle sustained while the output is not stalled; a query result
//  passes through the 25-stage coordinate divider and the four-bank store.
//  Reset restores register defaults and empties the pipeline; the frame store
//  is not cleared. An output stall freezes the back end; the four-entry queue
//  keeps taking input until it fills.
`timescale 1ns / 1ps
module image_resize_interpolator_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            func,
  input  logic [iri_pkg::POSW-1:0]        col,
  input  logic [iri_pkg::POSW-1:0]        row,
  input  logic [iri_pkg::CHW-1:0]         chan,
  input  logic [iri_pkg::SAMPLE_BITS-1:0] sample_in,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [iri_pkg::SAMPLE_BITS-1:0] sample_out,
  output logic                            status,
  input  logic                            cfg_we,
  input  logic [iri_pkg::IDXW-1:0]        cfg_index,
  input  logic [iri_pkg::CFGW-1:0]        cfg_data
);
  import iri_pkg::*;

  logic [SRCW-1:0] src_width, src_height;
  logic [CNTW-1:0] channel_count;
  logic [DSTW-1:0] dst_width, dst_height;
  logic            interp_mode;

  cfg_t   cfg;
  entry_t entry, q_data;
  logic   push, q_ready, q_valid, pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width     <= SRCW'(256);
      src_height    <= SRCW'(256);
      channel_count <= CNTW'(3);
      dst_width     <= DSTW'(256);
      dst_height    <= DSTW'(256);
      interp_mode   <= MODE_BILINEAR;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SRC_WIDTH:     src_width     <= cfg_data[SRCW-1:0];
        REG_SRC_HEIGHT:    src_height    <= cfg_data[SRCW-1:0];
        REG_CHANNEL_COUNT: channel_count <= cfg_data[CNTW-1:0];
        REG_DST_WIDTH:     dst_width     <= cfg_data[DSTW-1:0];
        REG_DST_HEIGHT:    dst_height    <= cfg_data[DSTW-1:0];
        REG_INTERP_MODE:   interp_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.sw = (src_width == '0) ? SRCW'(1) :
             (32'(src_width) > MAX_WIDTH) ? SRCW'(MAX_WIDTH) : src_width;
    cfg.sh = (src_height == '0) ? SRCW'(1) :
             (32'(src_height) > MAX_HEIGHT) ? SRCW'(MAX_HEIGHT) : src_height;
    cfg.nc = (channel_count == '0) ? CNTW'(1) :
             (32'(channel_count) > MAX_CHANNELS) ? CNTW'(MAX_CHANNELS) : channel_count;
    cfg.dw = (dst_width == '0) ? DSTW'(1) :
             (32'(dst_width) > DST_LIMIT) ? DSTW'(DST_LIMIT) : dst_width;
    cfg.dh = (dst_height == '0) ? DSTW'(1) :
             (32'(dst_height) > DST_LIMIT) ? DSTW'(DST_LIMIT) : dst_height;
    cfg.mode = interp_mode;
  end

  iri_front u_front (
    .in_valid(in_valid), .in_ready(in_ready), .func(func), .col(col), .row(row),
    .chan(chan), .sample_in(sample_in), .cfg(cfg), .q_ready(q_ready),
    .push(push), .entry(entry)
  );

  iri_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_data(entry), .q_ready(q_ready),
    .pop(pop), .q_valid(q_valid), .q_data(q_data)
  );

  iri_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .q_valid(q_valid), .q_data(q_data), .pop(pop),
    .out_valid(out_valid), .out_ready(out_ready), .sample_out(sample_out),
    .status(status)
  );

`ifndef SYNTH
  a_full_not_empty: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> q_valid) else $error("queue full while empty");
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid) else $error("pop from empty queue");
  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> sample_out == '0) else $error("flagged result not zero");
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid) else $error("result right after reset");
`endif

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for the image resize interpolator core.
`timescale 1ns / 1ps
module tb;
  import iri_pkg::*;

  localparam int LATENCY   = 64;
  localparam int WDOG_MAX  = 4000;
  localparam int STORE_N   = MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS;
  localparam int ITEM_GOAL = 1350;

  typedef struct {
    logic                   func;
    logic [POSW-1:0]        col;
    logic [POSW-1:0]        row;
    logic [CHW-1:0]         chan;
    logic [SAMPLE_BITS-1:0] sample;
    int                     gap;
  } pix_item_t;

  typedef struct {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   status;
  } pix_result_t;

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  logic                   func;
  logic [POSW-1:0]        col;
  logic [POSW-1:0]        row;
  logic [CHW-1:0]         chan;
  logic [SAMPLE_BITS-1:0] sample_in;
  logic                   out_valid;
  logic                   out_ready;
  logic [SAMPLE_BITS-1:0] sample_out;
  logic                   status;
  logic                   cfg_we;
  logic [IDXW-1:0]        cfg_index;
  logic [CFGW-1:0]        cfg_data;

  image_resize_interpolator_core dut (.*);

  logic [SAMPLE_BITS-1:0] frame_model [STORE_N];
  bit                     planned [STORE_N];
  logic [SRCW-1:0]        m_sw, m_sh;
  logic [CNTW-1:0]        m_nc;
  logic [DSTW-1:0]        m_dw, m_dh;
  logic                   m_mode;

  pix_item_t   pend_items[$];
  pix_result_t expected_pix[$];
  pix_item_t   cur, nxt;
  bit          have_next;
  int          wait_cnt;
  bit          in_xfer, out_xfer;
  int          stall_cnt;
  int          gap_max, stall_max;
  int          gen_cnt, sent_cnt, n_query, n_write, n_result, n_phase;
  int          err_cnt, idle_cyc;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint unsigned sat(longint unsigned v, longint unsigned hi);
    if (v < 1) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic longint unsigned center_q16(longint unsigned i, longint unsigned s,
                                                 longint unsigned d);
    longint unsigned num;
    num = ((2 * i + 1) * s) << 16;
    return (num + d) / (2 * d);
  endfunction

  function automatic longint unsigned src_sample(longint x, longint y, int c,
                                                 longint sw, longint sh);
    longint cx, cy;
    cx = (x < 0) ? 0 : ((x > sw - 1) ? sw - 1 : x);
    cy = (y < 0) ? 0 : ((y > sh - 1) ? sh - 1 : y);
    return frame_model[(cy * MAX_WIDTH + cx) * MAX_CHANNELS + c];
  endfunction

  function automatic pix_result_t scale_pixel(pix_item_t it);
    pix_result_t     r;
    longint unsigned sw, sh, nc, dw, dh, tx, ty, ux, uy, fx, fy, gx, gy, acc, res;
    longint          x1, y1;
    sw = sat(m_sw, MAX_WIDTH);
    sh = sat(m_sh, MAX_HEIGHT);
    nc = sat(m_nc, MAX_CHANNELS);
    dw = sat(m_dw, DST_LIMIT);
    dh = sat(m_dh, DST_LIMIT);
    r.sample = '0;
    r.status = 1'b1;
    if (it.col >= dw || it.row >= dh || it.chan >= nc) return r;
    tx = center_q16(it.col, sw, dw);
    ty = center_q16(it.row, sh, dh);
    if (m_mode == MODE_NEAREST) begin
      res = src_sample(tx >> 16, ty >> 16, it.chan, sw, sh);
    end else begin
      ux = tx + 32768;
      uy = ty + 32768;
      x1 = longint'(ux >> 16) - 1;
      y1 = longint'(uy >> 16) - 1;
      fx = ux & 16'hFFFF;
      fy = uy & 16'hFFFF;
      gx = 65536 - fx;
      gy = 65536 - fy;
      acc = src_sample(x1, y1, it.chan, sw, sh) * (gx * gy)
          + src_sample(x1 + 1, y1, it.chan, sw, sh) * (fx * gy)
          + src_sample(x1, y1 + 1, it.chan, sw, sh) * (gx * fy)
          + src_sample(x1 + 1, y1 + 1, it.chan, sw, sh) * (fx * fy);
      res = (acc >> 32) + ((acc >> 31) & 1);
      if (res > 65535) res = 65535;
    end
    r.sample = res[SAMPLE_BITS-1:0];
    r.status = 1'b0;
    return r;
  endfunction

  always @(posedge clk) begin
    in_xfer  = 1'b0;
    out_xfer = 1'b0;
    if (!rst) begin
      if (in_valid && in_ready) begin
        in_xfer = 1'b1;
        sent_cnt++;
        if (cur.func == FUNC_WRITE) begin
          if (cur.col < MAX_WIDTH && cur.row < MAX_HEIGHT)
            frame_model[(cur.row * MAX_WIDTH + cur.col) * MAX_CHANNELS + cur.chan] =
              cur.sample;
        end else begin
          expected_pix.push_back(scale_pixel(cur));
        end
      end
      if (out_valid && out_ready) begin
        out_xfer = 1'b1;
        n_result++;
        if (expected_pix.size() == 0) begin
          $display("%0t: unexpected result sample_out=%h status=%b",
                   $time, sample_out, status);
          err_cnt++;
        end else begin
          pix_result_t e;
          e = expected_pix.pop_front();
          if (sample_out !== e.sample) begin
            $display("%0t: sample_out expected %h actual %h", $time, e.sample, sample_out);
            err_cnt++;
          end
          if (status !== e.status) begin
            $display("%0t: status expected %b actual %b", $time, e.status, status);
            err_cnt++;
          end
        end
      end
      idle_cyc = (in_xfer || out_xfer) ? 0 : idle_cyc + 1;
      if (idle_cyc >= WDOG_MAX) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_xfer) begin
      if (!have_next && pend_items.size() > 0) begin
        nxt       = pend_items.pop_front();
        wait_cnt  = nxt.gap;
        have_next = 1'b1;
      end
      if (have_next && wait_cnt == 0) begin
        cur       = nxt;
        have_next = 1'b0;
        func      <= nxt.func;
        col       <= nxt.col;
        row       <= nxt.row;
        chan      <= nxt.chan;
        sample_in <= nxt.sample;
        in_valid  <= 1'b1;
      end else begin
        if (have_next) wait_cnt--;
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (out_xfer) stall_cnt = $urandom_range(0, stall_max);
    if (rst || stall_cnt == 0) begin
      out_ready <= 1'b1;
    end else begin
      stall_cnt--;
      out_ready <= 1'b0;
    end
  end

  task automatic add_item(logic f, int c, int r, int ch, int s);
    pix_item_t it;
    it.func   = f;
    it.col    = POSW'(c);
    it.row    = POSW'(r);
    it.chan   = CHW'(ch);
    it.sample = SAMPLE_BITS'(s);
    it.gap    = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
    if (f == FUNC_WRITE && c < MAX_WIDTH && r < MAX_HEIGHT)
      planned[(r * MAX_WIDTH + c) * MAX_CHANNELS + ch] = 1'b1;
    if (f == FUNC_WRITE) n_write++;
    else n_query++;
    pend_items.push_back(it);
    gen_cnt++;
  endtask

  task automatic wait_drained();
    while (sent_cnt != gen_cnt || expected_pix.size() != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  task automatic reg_write(logic [IDXW-1:0] idx, int val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFGW'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_geometry(int sw, int sh, int nc, int dw, int dh, int md);
    int x, y, c, xs, ys, cs;
    wait_drained();
    reg_write(REG_SRC_WIDTH, sw);
    reg_write(REG_SRC_HEIGHT, sh);
    reg_write(REG_CHANNEL_COUNT, nc);
    reg_write(REG_DST_WIDTH, dw);
    reg_write(REG_DST_HEIGHT, dh);
    reg_write(REG_INTERP_MODE, md);
    m_sw   = SRCW'(sw);
    m_sh   = SRCW'(sh);
    m_nc   = CNTW'(nc);
    m_dw   = DSTW'(dw);
    m_dh   = DSTW'(dh);
    m_mode = md[0];
    n_phase++;
    gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 18;
    stall_max = ($urandom_range(0, 3) == 0) ? 0 : 18;
    xs = int'(sat(m_sw, MAX_WIDTH));
    ys = int'(sat(m_sh, MAX_HEIGHT));
    cs = int'(sat(m_nc, MAX_CHANNELS));
    for (y = 0; y < ys; y++)
      for (x = 0; x < xs; x++)
        for (c = 0; c < cs; c++)
          if (!planned[(y * MAX_WIDTH + x) * MAX_CHANNELS + c])
            add_item(FUNC_WRITE, x, y, c, $urandom_range(0, 65535));
  endtask

  task automatic random_traffic(int n);
    int i, k, xs, ys, cs, dw, dh, s;
    xs = int'(sat(m_sw, MAX_WIDTH));
    ys = int'(sat(m_sh, MAX_HEIGHT));
    cs = int'(sat(m_nc, MAX_CHANNELS));
    dw = int'(sat(m_dw, DST_LIMIT));
    dh = int'(sat(m_dh, DST_LIMIT));
    for (i = 0; i < n; i++) begin
      k = $urandom_range(0, 19);
      s = $urandom_range(0, 65535);
      if (k < 3) begin
        if ($urandom_range(0, 7) == 0) s = 65535;
        add_item(FUNC_WRITE, $urandom_range(0, xs - 1), $urandom_range(0, ys - 1),
                 $urandom_range(0, cs - 1), s);
      end else if (k == 3) begin
        add_item(FUNC_WRITE, $urandom_range(0, 4095), $urandom_range(0, 4095),
                 $urandom_range(0, 3), s);
      end else if (k == 4) begin
        add_item(FUNC_QUERY, $urandom_range(0, 4095), $urandom_range(0, 4095),
                 $urandom_range(0, 3), s);
      end else begin
        add_item(FUNC_QUERY, $urandom_range(0, dw - 1), $urandom_range(0, dh - 1),
                 $urandom_range(0, cs - 1), s);
      end
    end
  endtask

  initial begin
    in_valid  = 1'b0;
    func      = FUNC_WRITE;
    col       = '0;
    row       = '0;
    chan      = '0;
    sample_in = '0;
    out_ready = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    stall_cnt = 0;
    rst       = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    reg_write(3'd6, 13'h1FFF);
    reg_write(3'd7, 13'h0ABC);
    set_geometry(4, 3, 4, 9, 7, MODE_BILINEAR);
    gap_max = 0;
    add_item(FUNC_WRITE, 0, 0, 0, 16'h0000);
    add_item(FUNC_WRITE, 3, 2, 3, 16'hFFFF);
    add_item(FUNC_WRITE, 4095, 4095, 3, 16'h1234);
    add_item(FUNC_WRITE, 255, 255, 2, 16'hA5A5);
    add_item(FUNC_QUERY, 0, 0, 0, 16'hFFFF);
    add_item(FUNC_QUERY, 8, 6, 3, 0);
    add_item(FUNC_QUERY, 4, 3, 1, 0);
    add_item(FUNC_QUERY, 9, 0, 0, 0);
    add_item(FUNC_QUERY, 0, 7, 0, 0);
    add_item(FUNC_QUERY, 4095, 4095, 3, 0);
    add_item(FUNC_WRITE, 1, 1, 1, 16'hFFFF);
    add_item(FUNC_QUERY, 2, 3, 1, 0);
    set_geometry(4, 3, 3, 9, 7, MODE_NEAREST);
    add_item(FUNC_QUERY, 0, 0, 0, 0);
    add_item(FUNC_QUERY, 8, 6, 2, 0);
    add_item(FUNC_QUERY, 5, 3, 3, 0);
    add_item(FUNC_QUERY, 4, 3, 1, 0);

    set_geometry(0, 0, 0, 0, 0, MODE_NEAREST);
    random_traffic(20);
    set_geometry(511, 1, 1, 4096, 8191, MODE_BILINEAR);
    random_traffic(80);
    set_geometry(1, 256, 1, 3, 4096, MODE_NEAREST);
    random_traffic(60);
    set_geometry(256, 1, 1, 4095, 1, MODE_NEAREST);
    random_traffic(60);
    set_geometry(5, 7, 2, 13, 11, MODE_BILINEAR);
    random_traffic(100);
    set_geometry(9, 6, 3, 5, 4, MODE_NEAREST);
    random_traffic(60);
    while (gen_cnt < ITEM_GOAL) begin
      set_geometry($urandom_range(0, 9), $urandom_range(0, 9), $urandom_range(0, 5),
                   $urandom_range(0, 40), $urandom_range(0, 40), $urandom_range(0, 1));
      random_traffic(60);
    end

    wait_drained();
    $display("Covered %0d phases: %0d writes and %0d queries, %0d results checked.",
             n_phase, n_write, n_query, n_result);
    if (err_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
